// ===== design/multichannel_button_debouncer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel button debouncer
// Each macro is checked on the rising edge of clk and is held off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_BUTTON_DEBOUNCER_MACROS_SVH
`define MULTICHANNEL_BUTTON_DEBOUNCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbd_pkg
// Shared constants and types of the multichannel button debouncer.
// ----------------------------------------------------------------------------
package mcbd_pkg;

  localparam int CHANNELS  = 16;
  localparam int CNT_W     = 8;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RISE_TICKS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FALL_TICKS  = 2'd2;

  localparam logic [CNT_W-1:0] RISE_RESET = 8'd2;
  localparam logic [CNT_W-1:0] FALL_RESET = 8'd2;

  typedef logic [CHANNELS-1:0] chan_vec_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef struct packed {
    chan_vec_t enable_mask;
    cnt_t      rise_ticks;
    cnt_t      fall_ticks;
  } cfg_t;

endpackage

// ===== design/mcbd_if.sv =====
// ----------------------------------------------------------------------------
// mcbd_in_if / mcbd_out_if
// Valid/ready channels carrying raw and debounced button levels.
// ----------------------------------------------------------------------------
interface mcbd_in_if;
  logic                            valid;
  logic                            ready;
  logic [mcbd_pkg::CHANNELS-1:0]   raw_levels;

  modport source (output valid, output raw_levels, input ready);
  modport sink   (input valid, input raw_levels, output ready);
endinterface

interface mcbd_out_if;
  logic                            valid;
  logic                            ready;
  logic [mcbd_pkg::CHANNELS-1:0]   stable_levels;

  modport source (output valid, output stable_levels, input ready);
  modport sink   (input valid, input stable_levels, output ready);
endinterface

// ===== design/mcbd_apb_regs.sv =====
// ----------------------------------------------------------------------------
// mcbd_apb_regs
// APB-style configuration registers: enable mask and the two thresholds.
// ----------------------------------------------------------------------------
module mcbd_apb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mcbd_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [mcbd_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [mcbd_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output mcbd_pkg::cfg_t                cfg
);
  import mcbd_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_ENABLE_MASK: cfg_nxt.enable_mask = cfg_pwdata[CHANNELS-1:0];
        REG_RISE_TICKS:  cfg_nxt.rise_ticks  = cfg_pwdata[CNT_W-1:0];
        REG_FALL_TICKS:  cfg_nxt.fall_ticks  = cfg_pwdata[CNT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_mask <= '0;
      cfg_r.rise_ticks  <= RISE_RESET;
      cfg_r.fall_ticks  <= FALL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE_MASK: cfg_prdata = DATA_W'(cfg_r.enable_mask);
      REG_RISE_TICKS:  cfg_prdata = DATA_W'(cfg_r.rise_ticks);
      REG_FALL_TICKS:  cfg_prdata = DATA_W'(cfg_r.fall_ticks);
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== design/mcbd_cell.sv =====
// ----------------------------------------------------------------------------
// mcbd_cell
// One channel: stable level and disagreement counter with its threshold.
// ----------------------------------------------------------------------------
module mcbd_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 update,
  input  logic                 raw_level,
  input  mcbd_pkg::cnt_t       rise_ticks,
  input  mcbd_pkg::cnt_t       fall_ticks,
  output logic                 stable,
  output logic                 stable_nxt
);
  import mcbd_pkg::*;

  logic           stable_r;
  cnt_t           cnt_r;
  cnt_t           cnt_nxt;
  cnt_t           thr;
  logic [CNT_W:0] cnt_inc;

  assign thr     = stable_r ? fall_ticks : rise_ticks;
  assign cnt_inc = {1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    stable_nxt = stable_r;
    cnt_nxt    = cnt_r;
    if (update) begin
      if (raw_level != stable_r) begin
        // A zero threshold behaves as one, as the incremented count always meets it.
        if (cnt_inc >= {1'b0, thr}) begin
          cnt_nxt    = '0;
          stable_nxt = ~stable_r;
        end else begin
          cnt_nxt = cnt_inc[CNT_W-1:0];
        end
      end else if (cnt_r != '0) begin
        cnt_nxt = cnt_r - {{(CNT_W-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      stable_r <= stable_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign stable = stable_r;

endmodule

// ===== design/multichannel_button_debouncer.sv =====
// ----------------------------------------------------------------------------
// multichannel_button_debouncer
// A request is held in the input stage, then its result is registered in the output stage and offered.
// Throughput: one request per cycle while the output is not stalled; all enabled channel cells update in parallel.
// Reset (synchronous, active low) clears stable levels, counters and the valid flags of both
// pipeline stages, and sets the thresholds to two and the enable mask to zero.
// ----------------------------------------------------------------------------
module multichannel_button_debouncer (
  input  logic                          clk,
  input  logic                          rst_n,
  mcbd_in_if.sink                       in_ch,
  mcbd_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mcbd_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [mcbd_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [mcbd_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import mcbd_pkg::*;

  `include "multichannel_button_debouncer_macros.svh"

  cfg_t      cfg;
  logic      s1_valid_r;
  chan_vec_t s1_raw_r;
  logic      out_valid_r;
  chan_vec_t out_data_r;
  logic      advance;
  logic      fire;
  chan_vec_t stable_vec;
  chan_vec_t stable_nxt_vec;

  mcbd_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // The result register moves on whenever it is empty or being taken.
  assign advance     = ~out_valid_r | out_ch.ready;
  assign fire        = s1_valid_r & advance;
  assign in_ch.ready = ~s1_valid_r | advance;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_cell
    mcbd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .update     (fire & cfg.enable_mask[c]),
      .raw_level  (s1_raw_r[c]),
      .rise_ticks (cfg.rise_ticks),
      .fall_ticks (cfg.fall_ticks),
      .stable     (stable_vec[c]),
      .stable_nxt (stable_nxt_vec[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_raw_r <= in_ch.raw_levels;
    end
    if (fire) begin
      out_data_r <= stable_nxt_vec;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.stable_levels = out_data_r;

  `MCBD_ASSERT_NEXT(a_idle_state_holds, !fire, $stable(stable_vec), "stable levels moved without a request")
  `MCBD_ASSERT_NEXT(a_result_matches_state, fire, out_data_r == stable_vec, "result differs from channel state")
  `MCBD_ASSERT_NEXT(a_disabled_frozen, fire, ((stable_vec ^ $past(stable_vec)) & ~$past(cfg.enable_mask)) == '0, "disabled channel changed level")
  `MCBD_ASSERT_SAME(a_no_drop, s1_valid_r && out_valid_r && !out_ch.ready, !in_ch.ready && !fire, "request taken while pipeline blocked")

endmodule
